### hdl/salc_pkg.sv
package salc_pkg;

  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;
  localparam int WAY_IDX_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [1:0] EVICT_NONE = 2'd0;
  localparam logic [1:0] EVICT_CLEAN = 2'd1;
  localparam logic [1:0] EVICT_DIRTY = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic        op;
    logic [63:0] addr;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         eviction;
    logic [2:0]         way_used;
    logic [63:0]        victim_tag;
    logic [COUNT_W-1:0] hits_total;
    logic [COUNT_W-1:0] misses_total;
    logic [COUNT_W-1:0] clean_evictions_total;
    logic [COUNT_W-1:0] dirty_evictions_total;
  } result_t;

  // Outcome of the tag compare and replacement choice for one set.
  typedef struct packed {
    logic                 hit;
    logic                 replace;
    logic [WAY_IDX_W-1:0] way;
  } decision_t;

endpackage

### hdl/salc_set_store.sv
module salc_set_store
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rd_en,
  input  logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] rd_set,
  input  logic                                 wr_en,
  input  logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] wr_set,
  input  logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] wr_way,
  input  logic                                 wr_dirty,
  input  logic [ADDR_WIDTH-1:0]                wr_tag,
  input  logic [STAMP_W-1:0]                   wr_stamp,
  output logic                                 clearing,
  output logic [MAX_WAYS-1:0]                  rd_valid,
  output logic [MAX_WAYS-1:0]                  rd_dirty,
  output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  rd_tag,
  output logic [MAX_WAYS-1:0][STAMP_W-1:0]     rd_stamp
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH = 1 << SET_W;

  // Flags are cleared after reset; tags and stamps are only read behind a valid bit.
  logic [MAX_WAYS-1:0]                 valid_mem [DEPTH];
  logic [MAX_WAYS-1:0]                 dirty_mem [DEPTH];
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem [DEPTH];
  logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp_mem [DEPTH];

  logic [SET_W:0] clr_idx;
  logic [MAX_WAYS-1:0] valid_row;
  logic [MAX_WAYS-1:0] dirty_row;

  assign clearing = !clr_idx[SET_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // The read registers still hold the row of the set being written.
  always_comb begin
    valid_row = rd_valid;
    dirty_row = rd_dirty;
    valid_row[wr_way] = 1'b1;
    dirty_row[wr_way] = wr_dirty;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_idx[SET_W-1:0]] <= '0;
      dirty_mem[clr_idx[SET_W-1:0]] <= '0;
    end else if (wr_en) begin
      valid_mem[wr_set] <= valid_row;
      dirty_mem[wr_set] <= dirty_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_set][wr_way] <= wr_tag;
      stamp_mem[wr_set][wr_way] <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid <= valid_mem[rd_set];
      rd_dirty <= dirty_mem[rd_set];
      rd_tag <= tag_mem[rd_set];
      rd_stamp <= stamp_mem[rd_set];
    end
  end

endmodule

### hdl/salc_way_select.sv
module salc_way_select
  import salc_pkg::*;
#(
  parameter int MAX_WAYS = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic [MAX_WAYS-1:0]                 way_en,
  input  logic [MAX_WAYS-1:0]                 valid,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tags,
  input  logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamps,
  input  logic [ADDR_WIDTH-1:0]               tag,
  output decision_t                           decision
);

  localparam int LVL = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
  localparam int LEAVES = 1 << LVL;
  localparam int PAD_W = LEAVES * STAMP_W;

  logic [MAX_WAYS-1:0]              live;
  logic [LEAVES-1:0]                cand_pad;
  logic [LEAVES-1:0][STAMP_W-1:0]   stamp_pad;
  logic                             node_ok [1:2*LEAVES-1];
  logic [STAMP_W-1:0]               node_stamp [1:2*LEAVES-1];
  logic [WAY_IDX_W-1:0]             node_way [1:2*LEAVES-1];
  logic                             found;
  logic [WAY_IDX_W-1:0]             found_way;
  logic                             has_empty;
  logic [WAY_IDX_W-1:0]             empty_way;

  assign live = way_en & valid;
  assign cand_pad = LEAVES'(live);
  assign stamp_pad = PAD_W'(stamps);

  // Lowest matching way and lowest free way; scanning downward lets the lowest win.
  always_comb begin
    found = 1'b0;
    found_way = '0;
    has_empty = 1'b0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (live[w] && tags[w] == tag) begin
        found = 1'b1;
        found_way = WAY_IDX_W'(w);
      end
      if (way_en[w] && !valid[w]) begin
        has_empty = 1'b1;
        empty_way = WAY_IDX_W'(w);
      end
    end
  end

  // Minimum-stamp tree; on equal stamps the left (lower) way is kept.
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_ok[LEAVES + i] = cand_pad[i];
      node_stamp[LEAVES + i] = stamp_pad[i];
      node_way[LEAVES + i] = WAY_IDX_W'(i);
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (node_ok[2*n+1] && (!node_ok[2*n] || node_stamp[2*n+1] < node_stamp[2*n])) begin
        node_ok[n] = 1'b1;
        node_stamp[n] = node_stamp[2*n+1];
        node_way[n] = node_way[2*n+1];
      end else begin
        node_ok[n] = node_ok[2*n];
        node_stamp[n] = node_stamp[2*n];
        node_way[n] = node_way[2*n];
      end
    end
  end

  always_comb begin
    decision.hit = found;
    decision.replace = !found && !has_empty;
    if (found) begin
      decision.way = found_way;
    end else if (has_empty) begin
      decision.way = empty_way;
    end else begin
      decision.way = node_way[1];
    end
  end

endmodule

### hdl/set_assoc_lru_writeback_cache_tags_core.sv
// Tag store of a set-associative write-back cache with LRU replacement. An access
// is taken at a rising edge where start is high and busy is low; its result is on
// result with done high for exactly one cycle, starting two edges after the one that
// took it, and must be captured then since the receiver cannot hold it off. A new
// access can be taken every three cycles: the whole set is read from the set memory
// at the edge that takes the access, the next cycle compares all ways and picks the
// LRU victim, the cycle after writes the chosen way back, and busy is low again in
// the cycle that shows the result. After reset a clearing pass zeroes the valid and
// dirty bits, one set per cycle over all sets of MAX_SET_BITS, and busy stays high
// for one cycle more than that pass. Configuration writes are taken only while no
// access is in flight, no result is showing and start is low.
module set_assoc_lru_writeback_cache_tags_core
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  request_t               req,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  state_t state;
  state_t state_next;

  logic [3:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_in_use;

  logic [COUNT_W-1:0] hit_cnt;
  logic [COUNT_W-1:0] miss_cnt;
  logic [COUNT_W-1:0] clean_cnt;
  logic [COUNT_W-1:0] dirty_cnt;

  logic                  cur_op;
  logic [ADDR_WIDTH-1:0] cur_tag;
  logic [SET_W-1:0]      cur_set;
  logic [MAX_WAYS-1:0]   cur_en;
  decision_t             dec;
  decision_t             dec_comb;

  logic                  accept;
  logic [ADDR_WIDTH-1:0] acc_addr;
  logic [4:0]            s_eff;
  logic [5:0]            shift_amt;
  logic [ADDR_WIDTH-1:0] set_mask;
  logic [ADDR_WIDTH-1:0] set_full;
  logic [SET_W-1:0]      acc_set;
  logic [ADDR_WIDTH-1:0] acc_tag;
  logic [5:0]            ways_eff;
  logic [MAX_WAYS-1:0]   acc_en;

  logic                                clearing;
  logic                                rd_en;
  logic                                wr_en;
  logic [WAY_W-1:0]                    wway;
  logic                                wr_dirty;
  logic [STAMP_W-1:0]                  stamp;
  logic [MAX_WAYS-1:0]                 rd_valid;
  logic [MAX_WAYS-1:0]                 rd_dirty;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]    rd_stamp;
  logic                                victim_dirty;

  // Registers change only between accesses, never under one in flight.
  assign cfg_ready = (state == ST_IDLE) && !done && !start;
  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= 4'd4;
      block_bits <= 5'd4;
      ways_in_use <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits <= cfg_data[3:0];
        CFG_BLOCK_BITS:  block_bits <= cfg_data[4:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Address split for the incoming item, with the set-bits and ways-in-use values clamped.
  always_comb begin
    acc_addr = req.addr[ADDR_WIDTH-1:0];
    s_eff = ({1'b0, set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, set_bits};
    shift_amt = {1'b0, block_bits} + {1'b0, s_eff};
    set_mask = ~({ADDR_WIDTH{1'b1}} << s_eff);
    set_full = (acc_addr >> block_bits) & set_mask;
    acc_set = set_full[SET_W-1:0];
    acc_tag = acc_addr >> shift_amt;
    if (ways_in_use == 4'd0) begin
      ways_eff = 6'd1;
    end else if ({2'b00, ways_in_use} > 6'(MAX_WAYS)) begin
      ways_eff = 6'(MAX_WAYS);
    end else begin
      ways_eff = {2'b00, ways_in_use};
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      acc_en[w] = 6'(w) < ways_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    wr_en = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (!clearing) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op <= req.op;
      cur_tag <= acc_tag;
      cur_set <= acc_set;
      cur_en <= acc_en;
    end
    if (state == ST_READ) begin
      dec <= dec_comb;
    end
  end

  salc_set_store #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS(MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .rd_en(rd_en),
    .rd_set(acc_set),
    .wr_en(wr_en),
    .wr_set(cur_set),
    .wr_way(wway),
    .wr_dirty(wr_dirty),
    .wr_tag(cur_tag),
    .wr_stamp(stamp),
    .clearing(clearing),
    .rd_valid(rd_valid),
    .rd_dirty(rd_dirty),
    .rd_tag(rd_tag),
    .rd_stamp(rd_stamp)
  );

  salc_way_select #(
    .MAX_WAYS(MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_select (
    .way_en(cur_en),
    .valid(rd_valid),
    .tags(rd_tag),
    .stamps(rd_stamp),
    .tag(cur_tag),
    .decision(dec_comb)
  );

  assign wway = dec.way[WAY_W-1:0];
  assign stamp = hit_cnt + miss_cnt;
  assign victim_dirty = rd_dirty[wway];
  assign wr_dirty = dec.hit ? (victim_dirty | cur_op) : cur_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt <= '0;
      miss_cnt <= '0;
      clean_cnt <= '0;
      dirty_cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= wr_en;
      if (wr_en) begin
        if (dec.hit) begin
          hit_cnt <= hit_cnt + 1'b1;
        end else begin
          miss_cnt <= miss_cnt + 1'b1;
        end
        if (dec.replace && victim_dirty) begin
          dirty_cnt <= dirty_cnt + 1'b1;
        end else if (dec.replace) begin
          clean_cnt <= clean_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      result.hit <= dec.hit;
      result.way_used <= dec.way[2:0];
      result.hits_total <= hit_cnt + COUNT_W'(dec.hit);
      result.misses_total <= miss_cnt + COUNT_W'(!dec.hit);
      result.clean_evictions_total <= clean_cnt + COUNT_W'(dec.replace && !victim_dirty);
      result.dirty_evictions_total <= dirty_cnt + COUNT_W'(dec.replace && victim_dirty);
      if (!dec.replace) begin
        result.eviction <= EVICT_NONE;
        result.victim_tag <= '0;
      end else begin
        result.eviction <= victim_dirty ? EVICT_DIRTY : EVICT_CLEAN;
        result.victim_tag <= 64'(rd_tag[wway]);
      end
    end
  end

  // A result is shown only in the cycle after a write-back.
  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WRITE))
    else $error("result strobe without a preceding write-back");

  // The set memory is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("set memory read and write overlap");

  // A hit never evicts, advances the hit count and leaves the miss count as it was.
  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> result.eviction == EVICT_NONE
      && result.misses_total == $past(miss_cnt)
      && result.hits_total == $past(hit_cnt) + 32'd1)
    else $error("hit result with inconsistent eviction or counters");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import salc_pkg::*;

  localparam int SET_LIMIT = 10;
  localparam int WAY_LIMIT = 8;
  localparam int LINES = (1 << SET_LIMIT) * WAY_LIMIT;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 163;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  request_t req;
  logic done;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  set_assoc_lru_writeback_cache_tags_core #(
    .MAX_SET_BITS(SET_LIMIT),
    .MAX_WAYS(WAY_LIMIT),
    .ADDR_WIDTH(64)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the tag store and its configuration.
  bit line_valid [LINES];
  bit line_dirty [LINES];
  logic [63:0] line_tag [LINES];
  logic [31:0] line_stamp [LINES];
  logic [31:0] exp_hits;
  logic [31:0] exp_misses;
  logic [31:0] clean_count;
  logic [31:0] dirty_count;
  logic [3:0] set_bits_reg;
  logic [4:0] block_bits_reg;
  logic [3:0] ways_reg;

  result_t pending_results [$];
  result_t oldest_result;
  int error_count;
  int idle_count;

  function automatic int eff_set_bits();
    return (set_bits_reg > SET_LIMIT) ? SET_LIMIT : int'(set_bits_reg);
  endfunction

  function automatic int eff_ways();
    if (ways_reg == 0) return 1;
    if (ways_reg > WAY_LIMIT) return WAY_LIMIT;
    return int'(ways_reg);
  endfunction

  // Looks up one access in the shadow store, updates it and returns the result.
  function automatic result_t cache_lookup(request_t r);
    int s;
    int b;
    int ways;
    int base;
    int e;
    int found;
    int empty;
    int oldest;
    int pick;
    logic [63:0] set_no;
    logic [63:0] tag;
    logic [31:0] stamp;
    logic [31:0] low;
    bit have_low;
    result_t res;
    s = eff_set_bits();
    b = block_bits_reg;
    ways = eff_ways();
    set_no = (r.addr >> b) & ((64'd1 << s) - 64'd1);
    tag = (s + b >= 64) ? 64'd0 : (r.addr >> (s + b));
    base = int'(set_no) * WAY_LIMIT;
    stamp = exp_hits + exp_misses;
    found = -1;
    empty = -1;
    oldest = 0;
    low = '0;
    have_low = 1'b0;
    for (int w = 0; w < ways; w++) begin
      e = base + w;
      if (line_valid[e]) begin
        if (found < 0 && line_tag[e] == tag) found = w;
        if (!have_low || line_stamp[e] < low) begin
          low = line_stamp[e];
          oldest = w;
          have_low = 1'b1;
        end
      end else if (empty < 0) begin
        empty = w;
      end
    end
    res = '0;
    res.eviction = EVICT_NONE;
    if (found >= 0) begin
      e = base + found;
      line_stamp[e] = stamp;
      if (r.op == OP_WRITE) line_dirty[e] = 1'b1;
      exp_hits = exp_hits + 1;
      res.hit = 1'b1;
      res.way_used = found[2:0];
    end else begin
      pick = (empty >= 0) ? empty : oldest;
      e = base + pick;
      exp_misses = exp_misses + 1;
      if (empty < 0) begin
        res.victim_tag = line_tag[e];
        if (line_dirty[e]) begin
          dirty_count = dirty_count + 1;
          res.eviction = EVICT_DIRTY;
        end else begin
          clean_count = clean_count + 1;
          res.eviction = EVICT_CLEAN;
        end
      end
      line_valid[e] = 1'b1;
      line_tag[e] = tag;
      line_stamp[e] = stamp;
      line_dirty[e] = (r.op == OP_WRITE);
      res.way_used = pick[2:0];
    end
    res.hits_total = exp_hits;
    res.misses_total = exp_misses;
    res.clean_evictions_total = clean_count;
    res.dirty_evictions_total = dirty_count;
    return res;
  endfunction

  // Builds an address from tag, set and offset under the current split.
  function automatic logic [63:0] make_addr(logic [63:0] tag, logic [63:0] set_no,
                                            logic [63:0] offset);
    int s;
    int b;
    logic [63:0] a;
    s = eff_set_bits();
    b = block_bits_reg;
    a = offset & ((64'd1 << b) - 64'd1);
    a = a | ((set_no & ((64'd1 << s) - 64'd1)) << b);
    if (s + b < 64) a = a | (tag << (s + b));
    return a;
  endfunction

  // Mostly a small pool of tags and sets so that hits and evictions are common.
  function automatic logic [63:0] random_addr();
    logic [63:0] tag;
    logic [63:0] set_no;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) tag = {$urandom, $urandom};
    else tag = 64'($urandom_range(0, eff_ways() + 2));
    if ($urandom_range(0, 4) == 0) set_no = 64'($urandom);
    else set_no = 64'($urandom_range(0, 3));
    return make_addr(tag, set_no, {$urandom, $urandom});
  endfunction

  // Leaves start high; the caller lowers it only when a gap follows.
  task automatic send_access(input logic op, input logic [63:0] addr);
    request_t r;
    r.op = op;
    r.addr = addr;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(cache_lookup(r));
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_SET_BITS: set_bits_reg = value[3:0];
      CFG_BLOCK_BITS: block_bits_reg = value[4:0];
      CFG_WAYS_IN_USE: ways_reg = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] s, input logic [7:0] b, input logic [7:0] w);
    write_reg(CFG_SET_BITS, s);
    write_reg(CFG_BLOCK_BITS, b);
    write_reg(CFG_WAYS_IN_USE, w);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (error_count < 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        if (error_count < 10) $display("%0t: result with no access pending", $realtime);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("hit", oldest_result.hit, result.hit);
        check_field("eviction", oldest_result.eviction, result.eviction);
        check_field("way_used", oldest_result.way_used, result.way_used);
        check_field("victim_tag", oldest_result.victim_tag, result.victim_tag);
        check_field("hits_total", oldest_result.hits_total, result.hits_total);
        check_field("misses_total", oldest_result.misses_total, result.misses_total);
        check_field("clean_evictions_total", oldest_result.clean_evictions_total,
                    result.clean_evictions_total);
        check_field("dirty_evictions_total", oldest_result.dirty_evictions_total,
                    result.dirty_evictions_total);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Field extremes and both eviction kinds with the reset configuration.
  task automatic test_reset_defaults();
    send_access(OP_READ, 64'h0);
    send_access(OP_WRITE, 64'h0);
    send_access(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(OP_READ, 64'h100);
    send_access(OP_READ, 64'h0);
    send_access(OP_READ, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(OP_WRITE, 64'h8000_0000_0000_0000);
    send_access(OP_READ, 64'h5555_5555_5555_5555);
    send_access(OP_WRITE, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();
  endtask

  // Fills four ways of one set, then checks the replacement order.
  task automatic test_lru_order();
    apply_config(8'd2, 8'd6, 8'd4);
    for (int t = 1; t <= 4; t++) send_access(OP_READ, make_addr(t, 1, 0));
    send_access(OP_WRITE, make_addr(2, 1, 5));
    send_access(OP_READ, make_addr(5, 1, 0));
    send_access(OP_READ, make_addr(6, 1, 63));
    send_access(OP_WRITE, make_addr(4, 1, 0));
    send_access(OP_READ, make_addr(7, 1, 0));
    drain();
  endtask

  // Lines beyond the ways in use are kept and come back when the ways grow.
  task automatic test_way_shrink();
    apply_config(8'd0, 8'd0, 8'd3);
    send_access(OP_READ, 64'd0);
    send_access(OP_WRITE, 64'd1);
    send_access(OP_READ, 64'd2);
    drain();
    apply_config(8'd0, 8'd0, 8'd1);
    send_access(OP_READ, 64'd2);
    drain();
    apply_config(8'd0, 8'd0, 8'd3);
    send_access(OP_READ, 64'd1);
    send_access(OP_READ, 64'd2);
    drain();
  endtask

  task automatic run_random(input int n);
    int burst;
    logic op;
    burst = $urandom_range(1, 30);
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
      send_access(op, random_addr());
      burst--;
      if (burst == 0) begin
        idle_cycles($urandom_range(1, 12));
        burst = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 30);
      end
    end
    drain();
  endtask

  // Extreme and out-of-range settings first, random ones after.
  task automatic test_random_configs();
    logic [7:0] s;
    logic [7:0] b;
    logic [7:0] w;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin s = 8'd4; b = 8'd4; w = 8'd1; end
        1: begin s = 8'd0; b = 8'd0; w = 8'd8; end
        2: begin s = 8'd10; b = 8'd16; w = 8'd8; end
        3: begin s = 8'd15; b = 8'd31; w = 8'd15; end
        4: begin s = 8'd0; b = 8'd31; w = 8'd0; end
        5: begin s = 8'd11; b = 8'd0; w = 8'd9; end
        6: begin s = 8'd1; b = 8'd2; w = 8'd2; end
        default: begin
          s = 8'($urandom_range(0, 15));
          b = 8'($urandom_range(0, 31));
          w = 8'($urandom_range(0, 15));
        end
      endcase
      apply_config(s, b, w);
      run_random(PHASE_ITEMS);
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SET_BITS;
    cfg_data <= '0;
    error_count = 0;
    idle_count = 0;
    exp_hits = '0;
    exp_misses = '0;
    clean_count = '0;
    dirty_count = '0;
    set_bits_reg = 4'd4;
    block_bits_reg = 5'd4;
    ways_reg = 4'd1;
    for (int i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_tag[i] = '0;
      line_stamp[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_lru_order();
    test_way_shrink();
    test_random_configs();

    drain();
    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
